// ----- rtl/core/pcot_pkg.sv -----
// pcot_pkg: shared types, codes and the object size function for the
// per-class object size tally. No dependencies.
package pcot_pkg;

  localparam int PCOT_TABLE_ENTRIES_DEF = 256;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_RECORDED = 3'd0;
  localparam logic [2:0] ST_BAD_KEY  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic [2:0] FMT_NONE   = 3'd7;
  localparam logic [2:0] FMT_BYTE_A = 3'd4;
  localparam logic [2:0] FMT_BYTE_B = 3'd5;

  typedef struct packed {
    logic [31:0] key;
    logic [30:0] count;
    logic [30:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] index;
    entry_t     ent;
    logic [8:0] used;
  } result_t;

  // header plus fixed slots, plus (unless the format is none) a repeated part scaled by the vector format
  function automatic logic [30:0] obj_bytes(input logic [30:0] flw,
                                            input logic [2:0]  fmt,
                                            input logic [30:0] rcw);
    logic [32:0] fixed4;
    logic [32:0] rep;
    logic [32:0] size;
    fixed4 = ({4'b0, flw[30:2]} + 33'd1) << 2;
    rep    = {4'b0, rcw[30:2]};
    if (fmt == FMT_NONE) begin
      size = fixed4;
    end else if (fmt == FMT_BYTE_A || fmt == FMT_BYTE_B) begin
      size = fixed4 + 33'd4 + rep;
    end else begin
      size = fixed4 + 33'd4 + (rep << 2);
    end
    return (size > {2'b00, SAT31}) ? SAT31 : size[30:0];
  endfunction

endpackage

// ----- rtl/core/pcot_table.sv -----
// pcot_table: entry memory of the tally, one write port and one read port
// with registered read data. Depends on pcot_pkg.
module pcot_table #(
  parameter int TABLE_ENTRIES = pcot_pkg::PCOT_TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  pcot_pkg::entry_t    wr_data,
  input  logic [IDX_W-1:0]    rd_addr,
  output pcot_pkg::entry_t    rd_data
);
  import pcot_pkg::*;

  entry_t mem_r [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/per_class_object_size_tally.sv -----
// per_class_object_size_tally: per-class object count and byte tally.
// Record: scans the filled entries, one table entry compared per cycle
// through the single memory read port, then updates the entry. Every
// result waits while the output stalls. One item at a time; in_stall is
// high while an item is in work. Reset empties the table at once by
// clearing the fill count; entries past it read as zero, no clearing pass.
module per_class_object_size_tally #(
  parameter int TABLE_ENTRIES = pcot_pkg::PCOT_TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_class_key,
  input  logic [30:0] in_fixed_length_word,
  input  logic [2:0]  in_vector_format,
  input  logic [30:0] in_repeat_count_word,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [31:0] out_entry_key,
  output logic [30:0] out_entry_count,
  output logic [30:0] out_entry_bytes,
  output logic [8:0]  out_entries_used
);
  import pcot_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > 9) ? FILL_W : 9;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_UPD, S_EMIT} state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [30:0]         size_r, size_nxt;
  logic [FILL_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  entry_t              ent_r, ent_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [7:0]          rd_index_r, rd_index_nxt;
  result_t             res_r, res_nxt;
  result_t             out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_fire;
  logic [CMP_W-1:0]    rd_idx_w;
  logic [CMP_W-1:0]    fill_w;
  logic [CMP_W-1:0]    hit_w;
  logic [8:0]          used_w;
  logic                bad_key;
  logic                table_full;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;
  logic                wr_en;
  entry_t              upd_ent;
  logic [31:0]         bytes_sum;

  assign in_stall   = (state_r != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign rd_idx_w   = CMP_W'(in_read_index);
  assign fill_w     = CMP_W'(fill_r);
  assign hit_w      = CMP_W'(hit_idx_r);
  assign used_w     = fill_w[8:0];
  assign bad_key    = (in_class_key == 32'd0) || (in_class_key[1:0] != 2'b00);
  assign table_full = (fill_r == FILL_W'(TABLE_ENTRIES));
  assign rd_addr    = (state_r == S_IDLE) ? rd_idx_w[IDX_W-1:0]
                                          : scan_idx_r[IDX_W-1:0];
  assign wr_en      = (state_r == S_UPD);

  // saturating update of the selected entry
  assign bytes_sum = {1'b0, ent_r.bytes} + {1'b0, size_r};
  always_comb begin
    upd_ent.key   = ent_r.key;
    upd_ent.count = (ent_r.count == SAT31) ? SAT31 : ent_r.count + 31'd1;
    upd_ent.bytes = bytes_sum[31] ? SAT31 : bytes_sum[30:0];
  end

  pcot_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hit_idx_r),
    .wr_data (upd_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_idx_nxt   = hit_idx_r;
    ent_nxt       = ent_r;
    rd_ok_nxt     = rd_ok_r;
    rd_index_nxt  = rd_index_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_RECORD: begin
              if (bad_key) begin
                res_nxt   = '{ST_BAD_KEY, 8'd0, '0, used_w};
                state_nxt = S_EMIT;
              end else begin
                key_nxt      = in_class_key;
                size_nxt     = obj_bytes(in_fixed_length_word, in_vector_format,
                                         in_repeat_count_word);
                scan_idx_nxt = '0;
                pend_nxt     = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            REQ_READ: begin
              rd_ok_nxt    = (rd_idx_w < fill_w);
              rd_index_nxt = in_read_index;
              state_nxt    = S_READ;
            end
            REQ_CLEAR: begin
              fill_nxt  = '0;
              res_nxt   = '{ST_CLEARED, 8'd0, '0, 9'd0};
              state_nxt = S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        res_nxt   = '{ST_READ, rd_index_r, (rd_ok_r ? rd_data : '0), used_w};
        state_nxt = S_EMIT;
      end

      // reads run one entry ahead of the compare
      S_SCAN: begin
        if (pend_r && rd_data.key == key_r) begin
          hit_idx_nxt = pend_idx_r;
          ent_nxt     = rd_data;
          state_nxt   = S_UPD;
        end else if (scan_idx_r == fill_r) begin
          if (table_full) begin
            res_nxt   = '{ST_FULL, 8'd0, '0, used_w};
            state_nxt = S_EMIT;
          end else begin
            hit_idx_nxt = fill_r[IDX_W-1:0];
            ent_nxt     = '{key_r, 31'd0, 31'd0};
            fill_nxt    = fill_r + FILL_W'(1);
            state_nxt   = S_UPD;
          end
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + FILL_W'(1);
        end
      end

      S_UPD: begin
        res_nxt   = '{ST_RECORDED, hit_w[7:0], upd_ent, used_w};
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    ent_r      <= ent_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rd_index_r <= rd_index_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_entry_index  = out_r.index;
  assign out_entry_key    = out_r.ent.key;
  assign out_entry_count  = out_r.ent.count;
  assign out_entry_bytes  = out_r.ent.bytes;
  assign out_entries_used = out_r.used;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_CLEAR) |=> (fill_r == '0))
    else $error("clear did not empty the table");

  a_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (hit_w < fill_w))
    else $error("entry write outside filled region");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result transfer raised outside emit state");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for per_class_object_size_tally; drives record, read and
// clear requests and checks every result against an in-bench tally of the class table.
// Depends on pcot_pkg and the per_class_object_size_tally rtl.
module tb_top;
  import pcot_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int POOL_SIZE = 24;
  localparam int DRAIN_CYCLES = 300;
  localparam int RUN_LIMIT_CYCLES = 2_000_000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] key;
    logic [30:0] flw;
    logic [2:0]  fmt;
    logic [30:0] rcw;
    logic [7:0]  idx;
  } tally_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_class_key = '0;
  logic [30:0] in_fixed_length_word = '0;
  logic [2:0]  in_vector_format = '0;
  logic [30:0] in_repeat_count_word = '0;
  logic [7:0]  in_read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_entry_index;
  logic [31:0] out_entry_key;
  logic [30:0] out_entry_count;
  logic [30:0] out_entry_bytes;
  logic [8:0]  out_entries_used;

  per_class_object_size_tally dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_class_key        (in_class_key),
    .in_fixed_length_word(in_fixed_length_word),
    .in_vector_format    (in_vector_format),
    .in_repeat_count_word(in_repeat_count_word),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_entry_key       (out_entry_key),
    .out_entry_count     (out_entry_count),
    .out_entry_bytes     (out_entry_bytes),
    .out_entries_used    (out_entries_used)
  );

  always #4 clk = ~clk;

  // bench copy of the class table
  logic [31:0] key_tab [TABLE_DEPTH];
  logic [30:0] count_tab [TABLE_DEPTH];
  logic [30:0] bytes_tab [TABLE_DEPTH];
  int          tab_fill;

  tally_req_t  req_backlog[$];
  result_t     tally_replies_due[$];
  tally_req_t  cur_req;
  logic [31:0] key_pool [POOL_SIZE];

  int sender_idle_pct = 11;
  int recv_idle_pct = 48;
  int mismatch_count = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int status_tally [8];

  task automatic tally_wipe();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      key_tab[i] = '0;
      count_tab[i] = '0;
      bytes_tab[i] = '0;
    end
    tab_fill = 0;
  endtask

  // applies one request to the bench table and forms the reply it should cause
  task automatic tally_apply(input tally_req_t r, output bit produced, output result_t res);
    logic [33:0] sz;
    logic [33:0] sum;
    int          hit;
    bit          found;
    produced = 1'b1;
    res = '0;
    case (r.req)
      REQ_RECORD: begin
        if (r.key == 32'd0 || r.key[1:0] != 2'b00) begin
          res.status = ST_BAD_KEY;
          res.used = tab_fill[8:0];
        end else begin
          // header plus fixed slots in words, then the repeated part
          sz = ({5'b0, r.flw[30:2]} + 34'd1) << 2;
          if (r.fmt == FMT_BYTE_A || r.fmt == FMT_BYTE_B) begin
            sz = sz + 34'd4 + {5'b0, r.rcw[30:2]};
          end else if (r.fmt != FMT_NONE) begin
            sz = sz + 34'd4 + ({5'b0, r.rcw[30:2]} << 2);
          end
          if (sz > {3'b0, SAT31}) sz = {3'b0, SAT31};
          found = 1'b0;
          hit = 0;
          for (int i = 0; i < tab_fill; i++) begin
            if (!found && key_tab[i] == r.key) begin
              hit = i;
              found = 1'b1;
            end
          end
          if (!found && tab_fill >= TABLE_DEPTH) begin
            res.status = ST_FULL;
            res.used = tab_fill[8:0];
          end else begin
            if (!found) begin
              hit = tab_fill;
              key_tab[hit] = r.key;
              count_tab[hit] = '0;
              bytes_tab[hit] = '0;
              tab_fill++;
            end
            if (count_tab[hit] != SAT31) count_tab[hit] = count_tab[hit] + 31'd1;
            sum = {3'b0, bytes_tab[hit]} + sz;
            bytes_tab[hit] = (sum > {3'b0, SAT31}) ? SAT31 : sum[30:0];
            res.status = ST_RECORDED;
            res.index = hit[7:0];
            res.ent.key = key_tab[hit];
            res.ent.count = count_tab[hit];
            res.ent.bytes = bytes_tab[hit];
            res.used = tab_fill[8:0];
          end
        end
      end
      REQ_READ: begin
        res.status = ST_READ;
        res.index = r.idx;
        res.ent.key = key_tab[r.idx];
        res.ent.count = count_tab[r.idx];
        res.ent.bytes = bytes_tab[r.idx];
        res.used = tab_fill[8:0];
      end
      REQ_CLEAR: begin
        tally_wipe();
        res.status = ST_CLEARED;
      end
      default: begin
        produced = 1'b0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH @%0t %s: got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // driver: one request per transfer, valid held until taken
  always @(posedge clk) begin
    bit      produced;
    bit      load;
    result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      load = 1'b0;
      if (in_valid && !in_stall) begin
        tally_apply(cur_req, produced, res);
        if (produced) tally_replies_due.push_back(res);
        reqs_taken++;
        load = 1'b1;
      end else if (!in_valid) begin
        load = 1'b1;
      end
      if (load) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          cur_req = req_backlog.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.req;
          in_class_key <= cur_req.key;
          in_fixed_length_word <= cur_req.flw;
          in_vector_format <= cur_req.fmt;
          in_repeat_count_word <= cur_req.rcw;
          in_read_index <= cur_req.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each result transfer checked against the oldest reply due
  always @(posedge clk) begin
    result_t want;
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_tally[out_status]++;
      if (tally_replies_due.size() == 0) begin
        report_mismatch("result with nothing due, status", 32'(out_status), 32'd0);
      end else begin
        want = tally_replies_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_entry_index !== want.index)
          report_mismatch("entry_index", 32'(out_entry_index), 32'(want.index));
        if (out_entry_key !== want.ent.key)
          report_mismatch("entry_key", out_entry_key, want.ent.key);
        if (out_entry_count !== want.ent.count)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.ent.count));
        if (out_entry_bytes !== want.ent.bytes)
          report_mismatch("entry_bytes", 32'(out_entry_bytes), 32'(want.ent.bytes));
        if (out_entries_used !== want.used)
          report_mismatch("entries_used", 32'(out_entries_used), 32'(want.used));
      end
    end
  end

  function automatic tally_req_t mk_req(input logic [1:0] req, input logic [31:0] key,
                                        input logic [31:0] flw, input logic [31:0] fmt,
                                        input logic [31:0] rcw, input logic [31:0] idx);
    tally_req_t r;
    r.req = req;
    r.key = key;
    r.flw = flw[30:0];
    r.fmt = fmt[2:0];
    r.rcw = rcw[30:0];
    r.idx = idx[7:0];
    return r;
  endfunction

  // mostly small slot counts, now and then a full-width word to reach saturation
  function automatic logic [31:0] rnd_word();
    if ($urandom_range(0, 99) < 12) return $urandom;
    return $urandom_range(0, 1023);
  endfunction

  task automatic push_record(input logic [31:0] key);
    req_backlog.push_back(mk_req(REQ_RECORD, key, rnd_word(), $urandom_range(0, 7),
                                 rnd_word(), $urandom));
  endtask

  task automatic push_random(input int n);
    int          made;
    int          pick;
    logic [31:0] k;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        // unused code, dropped by the block
        req_backlog.push_back(mk_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                     $urandom));
      end else begin
        made++;
        if (pick < 66) begin
          push_record(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end else if (pick < 74) begin
          push_record($urandom);
        end else if (pick < 80) begin
          k = $urandom;
          k[1:0] = 2'b00;
          push_record(k);
        end else if (pick < 96) begin
          k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 255);
          req_backlog.push_back(mk_req(REQ_READ, $urandom, $urandom, $urandom, $urandom, k));
        end else begin
          req_backlog.push_back(mk_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                       $urandom));
        end
      end
    end
  endtask

  // empty table, fill all entries with distinct keys, then push past the end
  task automatic push_fill();
    logic [21:0] salt;
    logic [7:0]  pick;
    salt = 22'($urandom);
    salt[21] = 1'b1;
    req_backlog.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < TABLE_DEPTH; i++) push_record({salt, i[7:0], 2'b00});
    for (int i = 0; i < 6; i++) begin
      push_record({salt ^ 22'h1, i[7:0], 2'b00});
      pick = 8'($urandom_range(0, 255));
      push_record({salt, pick, 2'b00});
    end
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 255));
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || in_valid || tally_replies_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [31:0] k;
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
    tally_wipe();
    for (int i = 0; i < POOL_SIZE; i++) begin
      k = $urandom;
      k[1:0] = 2'b00;
      if (k == 32'd0) k = 32'h40;
      key_pool[i] = k;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty read, bad keys, size extremes, every vector format
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h0, 4, 0, 4, 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h1, 4, 0, 4, 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h2, 4, 0, 4, 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'hFFFF_FFFF, 32'(SAT31), 7, 32'(SAT31), 255));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'hFFFF_FFFC, 0, 32'(FMT_NONE), 32'(SAT31), 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h4, 32'(SAT31), 0, 32'(SAT31), 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h4, 32'(SAT31), 32'(FMT_NONE), 0, 0));
    req_backlog.push_back(mk_req(REQ_RECORD, 32'h8, 0, 32'(FMT_BYTE_A), 32'(SAT31), 0));
    for (int f = 0; f < 8; f++)
      req_backlog.push_back(mk_req(REQ_RECORD, 32'h100, $urandom_range(0, 255), f,
                                   $urandom_range(0, 255), 0));
    req_backlog.push_back(mk_req(REQ_UNUSED, 32'h100, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 255));
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 1));
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 3));
    req_backlog.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0));

    push_random(350);
    wait_idle();

    sender_idle_pct = 48;
    recv_idle_pct = 11;
    push_random(120);
    push_fill();
    push_random(120);
    wait_idle();

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(250);
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tally_replies_due.size() != 0)
      report_mismatch("replies never returned", 32'(tally_replies_due.size()), 32'd0);
    $display("covered %0d request transfers and %0d results: %0d recorded, %0d bad keys,",
             reqs_taken, results_seen, status_tally[ST_RECORDED], status_tally[ST_BAD_KEY]);
    $display("  %0d table-full drops, %0d reads, %0d clears",
             status_tally[ST_FULL], status_tally[ST_READ], status_tally[ST_CLEARED]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(8 * RUN_LIMIT_CYCLES);
    $display("timeout after %0d cycles", RUN_LIMIT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- per_class_object_size_tally.f -----
rtl/core/pcot_pkg.sv
rtl/core/pcot_table.sv
rtl/core/per_class_object_size_tally.sv
dv/tb_top.sv
